[rtl/ckc_pkg.sv]
// shared types, constants and helpers for the composite key compare core
`timescale 1ns / 1ps
package ckc_pkg;

    localparam int MAX_ATTRS    = 8;
    localparam int INT_BYTES    = 4;
    localparam int MAX_ATTR_LEN = 63;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;
    localparam int KINDS_W    = 8;
    localparam int LEN_W      = 6;
    localparam int LENS_W     = LEN_W * MAX_ATTRS;
    localparam int IDX_W      = 3;
    localparam int INT_ACC_W  = BYTE_W * (INT_BYTES - 1);
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = LENS_W;

    typedef enum logic [1:0] {
        ORDER_LESS    = 2'd0,
        ORDER_EQUAL   = 2'd1,
        ORDER_GREATER = 2'd2
    } order_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ATTR_COUNT   = 2'd0,
        CFG_ATTR_KINDS   = 2'd1,
        CFG_ATTR_LENGTHS = 2'd2
    } cfg_addr_t;

    // decoded attribute layout
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic [MAX_ATTRS-1:0]              is_str;
        logic [MAX_ATTRS-1:0][LEN_W-1:0]   len;
    } attr_cfg_t;

    // running compare state between words
    typedef struct packed {
        logic [IDX_W-1:0]     attr_index;
        logic [LEN_W-1:0]     byte_in_attr;
        logic                 decided;
        order_t               verdict;
        logic                 string_done;
        logic [INT_ACC_W-1:0] int_bytes_a;
        logic [INT_ACC_W-1:0] int_bytes_b;
    } cmp_state_t;

    function automatic cmp_state_t state_reset();
        cmp_state_t s;
        s.attr_index   = '0;
        s.byte_in_attr = '0;
        s.decided      = 1'b0;
        s.verdict      = ORDER_EQUAL;
        s.string_done  = 1'b0;
        s.int_bytes_a  = '0;
        s.int_bytes_b  = '0;
        return s;
    endfunction

endpackage

[rtl/ckc_cfg_regs.sv]
// configuration registers and attribute layout decode
`timescale 1ns / 1ps
module ckc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ckc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output ckc_pkg::attr_cfg_t             attr_cfg
);
    import ckc_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [KINDS_W-1:0] kinds_reg;
    logic [LENS_W-1:0]  lens_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(1);
            kinds_reg <= '0;
            lens_reg  <= LENS_W'(INT_BYTES);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ATTR_COUNT:   count_reg <= cfg_wr_data[CNT_W-1:0];
                CFG_ATTR_KINDS:   kinds_reg <= cfg_wr_data[KINDS_W-1:0];
                CFG_ATTR_LENGTHS: lens_reg  <= cfg_wr_data[LENS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp count and lengths, integers always take the fixed width
    always_comb begin
        logic [LEN_W-1:0] raw;
        attr_cfg.count  = (count_reg > CNT_W'(MAX_ATTRS)) ? CNT_W'(MAX_ATTRS) : count_reg;
        attr_cfg.is_str = kinds_reg[MAX_ATTRS-1:0];
        for (int i = 0; i < MAX_ATTRS; i++) begin
            raw = lens_reg[i*LEN_W +: LEN_W];
            if (!kinds_reg[i]) begin
                attr_cfg.len[i] = LEN_W'(INT_BYTES);
            end else if (raw > LEN_W'(MAX_ATTR_LEN)) begin
                attr_cfg.len[i] = LEN_W'(MAX_ATTR_LEN);
            end else begin
                attr_cfg.len[i] = raw;
            end
        end
    end

endmodule

[rtl/ckc_step.sv]
// per-word compare step: skip empty attributes, compare one byte pair
`timescale 1ns / 1ps
module ckc_step (
    input  ckc_pkg::attr_cfg_t             attr_cfg,
    input  ckc_pkg::cmp_state_t            cur_state,
    input  logic [ckc_pkg::BYTE_W-1:0]     byte_a,
    input  logic [ckc_pkg::BYTE_W-1:0]     byte_b,
    output ckc_pkg::cmp_state_t            next_state
);
    import ckc_pkg::*;

    logic [IDX_W-1:0]       cur;
    logic                   active;
    logic [LEN_W-1:0]       cur_len;
    logic [LEN_W:0]         byte_plus;
    logic [CNT_W-1:0]       idx_plus;
    logic [1:0]             int_pos;
    logic [BYTE_W*INT_BYTES-1:0] va;
    logic [BYTE_W*INT_BYTES-1:0] vb;
    logic                   stop;
    logic                   nxt_found;
    logic [IDX_W-1:0]       nxt_idx;

    // find the attribute this byte belongs to
    always_comb begin
        cur    = cur_state.attr_index;
        active = 1'b0;
        if (cur_state.decided) begin
            active = 1'b0;
        end else if (CNT_W'(cur_state.attr_index) >= attr_cfg.count) begin
            active = 1'b0;
        end else if (cur_state.byte_in_attr != '0) begin
            active = 1'b1;
        end else begin
            for (int j = 0; j < MAX_ATTRS; j++) begin
                if (!active && CNT_W'(j) >= CNT_W'(cur_state.attr_index)
                        && CNT_W'(j) < attr_cfg.count && attr_cfg.len[j] != '0) begin
                    active = 1'b1;
                    cur    = IDX_W'(j);
                end
            end
        end
    end

    assign cur_len   = attr_cfg.len[cur];
    assign byte_plus = {1'b0, cur_state.byte_in_attr} + (LEN_W+1)'(1);
    assign idx_plus  = CNT_W'(cur) + CNT_W'(1);
    assign int_pos   = cur_state.byte_in_attr[1:0];
    assign va        = {byte_a, cur_state.int_bytes_a};
    assign vb        = {byte_b, cur_state.int_bytes_b};

    // first non-empty attribute after the current one
    always_comb begin
        nxt_found = 1'b0;
        nxt_idx   = cur;
        for (int j = 0; j < MAX_ATTRS; j++) begin
            if (!nxt_found && CNT_W'(j) >= idx_plus
                    && CNT_W'(j) < attr_cfg.count && attr_cfg.len[j] != '0) begin
                nxt_found = 1'b1;
                nxt_idx   = IDX_W'(j);
            end
        end
    end

    always_comb begin
        next_state = cur_state;
        stop       = 1'b0;
        if (!active) begin
            // nothing left to compare
            next_state.decided = 1'b1;
            stop               = 1'b1;
        end else begin
            next_state.attr_index = cur;
            if (!attr_cfg.is_str[cur]) begin
                if (cur_state.byte_in_attr < LEN_W'(INT_BYTES - 1)) begin
                    next_state.int_bytes_a = cur_state.int_bytes_a
                        | (INT_ACC_W'(byte_a) << {int_pos, 3'b000});
                    next_state.int_bytes_b = cur_state.int_bytes_b
                        | (INT_ACC_W'(byte_b) << {int_pos, 3'b000});
                end else if (va != vb) begin
                    next_state.decided = 1'b1;
                    next_state.verdict = ($signed(va) < $signed(vb)) ? ORDER_LESS
                                                                     : ORDER_GREATER;
                    stop               = 1'b1;
                end
            end else if (!cur_state.string_done) begin
                if (byte_a != byte_b) begin
                    next_state.decided = 1'b1;
                    next_state.verdict = (byte_a < byte_b) ? ORDER_LESS : ORDER_GREATER;
                    stop               = 1'b1;
                end else if (byte_a == '0) begin
                    next_state.string_done = 1'b1;
                end
            end
            if (!stop) begin
                if (byte_plus >= {1'b0, cur_len}) begin
                    // attribute finished, move on to the next non-empty one
                    if (!nxt_found) begin
                        next_state.decided = 1'b1;
                    end else begin
                        next_state.attr_index = nxt_idx;
                    end
                    next_state.byte_in_attr = '0;
                    next_state.string_done  = 1'b0;
                    next_state.int_bytes_a  = '0;
                    next_state.int_bytes_b  = '0;
                end else begin
                    next_state.byte_in_attr = byte_plus[LEN_W-1:0];
                end
            end
        end
    end

endmodule

[rtl/composite_key_compare_core.sv]
// top level: lexicographic compare of two streamed multi-attribute keys
// throughput: one byte pair per cycle unless a final pair waits on a held result;
//   input register feeds a compare step that updates the running state and loads
//   the result register
// reset: synchronous active-low aresetn clears the handshakes and compare state
//   and loads the register defaults (one integer attribute)
`timescale 1ns / 1ps
module composite_key_compare_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [ckc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // input byte pairs
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ckc_pkg::BYTE_W-1:0]     s_byte_a,
    input  logic [ckc_pkg::BYTE_W-1:0]     s_byte_b,
    input  logic                           s_final_pair,
    // compare result
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_order
);
    import ckc_pkg::*;

    attr_cfg_t  attr_cfg;

    // input register stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_a_reg;
    logic [BYTE_W-1:0] in_byte_b_reg;
    logic              in_final_reg;

    // running compare state
    cmp_state_t state_reg;
    cmp_state_t state_next;

    // result register
    logic   out_valid_reg;
    order_t out_order_reg;

    logic consume;

    ckc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .attr_cfg    (attr_cfg)
    );

    ckc_step u_step (
        .attr_cfg   (attr_cfg),
        .cur_state  (state_reg),
        .byte_a     (in_byte_a_reg),
        .byte_b     (in_byte_b_reg),
        .next_state (state_next)
    );

    // a word without the final flag never needs the result register,
    // a final word waits only while an untaken result sits there
    assign consume = in_valid_reg && (!in_final_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload holds while the stage is stalled
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_a_reg <= s_byte_a;
            in_byte_b_reg <= s_byte_b;
            in_final_reg  <= s_final_pair;
        end
    end

    // compare state: advance per word, start over after the final pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= state_reset();
        end else if (consume) begin
            if (in_final_reg) begin
                state_reg <= state_reset();
            end else begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_final_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_final_reg) begin
            out_order_reg <= state_next.verdict;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_order = out_order_reg;

endmodule
